// ===== sv/cke_pkg.sv =====
// ----------------------------------------------------------------------------
// cke_pkg : shared types and helpers of the canonical k-mer extractor
// widths, state and result records, length clamp and k-mer mask
// ----------------------------------------------------------------------------
`default_nettype none

package cke_pkg;

  localparam int MAX_K     = 32;
  localparam int KMER_W    = 64;
  localparam int K_W       = 6;
  localparam int POS_W     = 32;
  localparam int OUT_POS_W = 32;
  localparam int CODE_W    = 3;

  localparam logic [K_W-1:0]   K_MIN      = K_W'(2);
  localparam logic [K_W-1:0]   K_MAX      = K_W'(MAX_K);
  localparam logic [K_W-1:0]   K_RESET    = K_W'(32);
  localparam logic [1:0]       COMP_MASK  = 2'h3;
  localparam logic [POS_W-1:0] IDX_LIMIT  = '1;

  typedef struct packed {
    logic [KMER_W-1:0] fwd;
    logic [KMER_W-1:0] rev;
    logic [K_W-1:0]    run;
    logic [POS_W-1:0]  idx;
  } cke_state_t;

  typedef struct packed {
    logic                 valid;
    logic [KMER_W-1:0]    kmer;
    logic [OUT_POS_W-1:0] pos;
  } cke_result_t;

  // clamp the programmed length into 2..MAX_K
  function automatic logic [K_W-1:0] eff_k(input logic [K_W-1:0] len);
    logic [K_W-1:0] k;
    k = len;
    if (k < K_MIN) k = K_MIN;
    if (k > K_MAX) k = K_MAX;
    return k;
  endfunction

  // one bit pair set for each base below k
  function automatic logic [KMER_W-1:0] kmer_mask(input logic [K_W-1:0] k);
    logic [KMER_W-1:0] m;
    m = '0;
    for (int j = 0; j < MAX_K; j++) begin
      m[2*j +: 2] = (K_W'(j) < k) ? 2'b11 : 2'b00;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cke_step.sv =====
// ----------------------------------------------------------------------------
// cke_step : next-state and result logic for one base
// rolls the forward and reverse-complement words and picks the smaller one
// ----------------------------------------------------------------------------
`default_nettype none

module cke_step (
  input  wire cke_pkg::cke_state_t       state_i,
  input  wire logic [cke_pkg::K_W-1:0]   kmer_length_i,
  input  wire logic [cke_pkg::CODE_W-1:0] base_code_i,
  input  wire logic                      seq_start_i,
  output cke_pkg::cke_state_t            state_o,
  output cke_pkg::cke_result_t           result_o
);
  import cke_pkg::*;

  logic [K_W-1:0]    k;
  logic [K_W-1:0]    k_m1;
  logic [KMER_W-1:0] mask;
  logic [KMER_W-1:0] ins;
  logic [1:0]        comp;
  cke_state_t        cur;
  logic [POS_W-1:0]  here;

  always_comb begin
    k    = eff_k(kmer_length_i);
    k_m1 = k - K_W'(1);
    mask = kmer_mask(k);
    comp = base_code_i[1:0] ^ COMP_MASK;
    ins  = '0;
    for (int j = 0; j < MAX_K; j++) begin
      ins[2*j +: 2] = (K_W'(j) == k_m1) ? comp : 2'b00;
    end

    // a sequence start wipes the state before the base is used
    cur  = seq_start_i ? '0 : state_i;
    here = cur.idx;

    state_o     = cur;
    state_o.idx = (here < IDX_LIMIT) ? here + POS_W'(1) : here;

    result_o       = '0;
    result_o.valid = 1'b0;

    if (base_code_i[2]) begin
      // unknown base breaks the run, words keep their bits
      state_o.run = '0;
    end else begin
      state_o.fwd = ({cur.fwd[KMER_W-3:0], base_code_i[1:0]}) & mask;
      state_o.rev = ({2'b00, cur.rev[KMER_W-1:2]} | ins) & mask;
      state_o.run = (cur.run < K_MAX) ? cur.run + K_W'(1) : cur.run;
      result_o.valid = (state_o.run >= k) && (here >= POS_W'(k_m1));
      result_o.kmer  = (state_o.fwd < state_o.rev) ? state_o.fwd : state_o.rev;
      result_o.pos   = OUT_POS_W'(here - POS_W'(k_m1));
    end
  end

endmodule

`default_nettype wire

// ===== sv/canonical_kmer_extractor_top.sv =====
// ----------------------------------------------------------------------------
// canonical_kmer_extractor_top : streaming canonical k-mer extractor
// one 3-bit base code per transfer in, canonical k-mer and its position out
// ----------------------------------------------------------------------------
// usage
//   input stream: one base per transfer, tdata[2:0] is the base code
//   (0..3 nucleotide, 4..7 unknown base), tuser[0] flags the first base
//   of a new sequence and clears all rolling state before that base
//   output stream: tdata[63:0] canonical k-mer, tdata[95:64] index of the
//   k-mer's first base in its sequence; a base gives a result only once
//   k valid bases are in a row, an unknown base never gives one
//   cfg port: kmer_length is written whenever cfg_wr_en_i is high; change
//   it only while no base is in flight. lengths below 2 act as 2, above
//   32 act as 32
//   path: a base passes the input register, then the result register,
//   and its result is taken into the result register when the slot is free
//   throughput: one base per cycle while the output is not stalled, set
//   by the combinational word update feeding the result register
//   stalls: the result register holds while m_axis_tready is low; the
//   input register keeps taking bases that give no result, and takes
//   any base as soon as the result slot drains
//   reset: clears the rolling words, run and position counters, both
//   valid flags, and sets kmer_length back to 32
// ----------------------------------------------------------------------------
`default_nettype none

module canonical_kmer_extractor_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write
  input  wire logic        cfg_wr_en_i,
  input  wire logic [5:0]  cfg_wr_data_i,   // kmer_length
  // base stream in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,    // [2:0] base_code, [7:3] zero
  input  wire logic [0:0]  s_axis_tuser,    // [0] sequence_start
  // k-mer stream out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata     // [63:0] canonical_kmer, [95:64] kmer_position
);
  import cke_pkg::*;

  // configuration register
  logic [K_W-1:0] kmer_len_q;

  // input register stage
  logic              s1_valid_q;
  logic [CODE_W-1:0] s1_code_q;
  logic              s1_start_q;

  // rolling state
  cke_state_t state_q;
  cke_state_t state_d;

  // result register stage
  logic                 out_valid_q;
  logic [KMER_W-1:0]    out_kmer_q;
  logic [OUT_POS_W-1:0] out_pos_q;

  cke_result_t res;
  logic        out_free;
  logic        s1_fire;
  logic        in_xfer;

  cke_step u_step (
    .state_i       (state_q),
    .kmer_length_i (kmer_len_q),
    .base_code_i   (s1_code_q),
    .seq_start_i   (s1_start_q),
    .state_o       (state_d),
    .result_o      (res)
  );

  // result slot is free when empty or draining this cycle
  assign out_free = !out_valid_q || m_axis_tready;
  // a base without a result never waits on the output side
  assign s1_fire  = s1_valid_q && (!res.valid || out_free);
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign in_xfer  = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_len_q <= K_RESET;
    end else if (cfg_wr_en_i) begin
      kmer_len_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_code_q  <= s_axis_tdata[CODE_W-1:0];
      s1_start_q <= s_axis_tuser[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_fire && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_fire && res.valid) begin
      out_kmer_q <= res.kmer;
      out_pos_q  <= res.pos;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_pos_q, out_kmer_q};

  // run counter saturates at the longest k-mer
  a_run_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.run <= K_MAX)
    else $error("valid run above max k");

  // a sequence start restarts the position count
  a_start_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_start_q |=> state_q.idx == POS_W'(1))
    else $error("position not restarted on sequence start");

  // an unknown base clears the run
  a_unknown_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_code_q[2] |=> state_q.run == '0)
    else $error("unknown base did not clear the run");

  // input only backs up behind a stalled result
  a_backpressure : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_valid_q && out_valid_q && !m_axis_tready)
    else $error("input stalled without output backpressure");

endmodule

`default_nettype wire
